// File: hw/rtl/cua_pkg.sv
package cua_pkg;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // fixed-point and time constants
    localparam int          FRAC_BITS     = 12;
    localparam logic [31:0] ANCHOR_MIN_US = 32'd100000;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;

    // seconds divider: base 2^16 long division by 1e6, one digit per two stages.
    // q = floor(v / 1e6) = floor((v >> 6) / 15625); the reciprocal estimate is
    // low by at most one and gets one correction step.
    localparam int          DIGIT_W     = 16;
    localparam int          N_DIGITS    = 4;
    localparam int          REM_W       = 20;
    localparam int          V_W         = REM_W + DIGIT_W;
    localparam int          RECIP_SHIFT = 44;
    localparam logic [30:0] RECIP_M     = 31'd1125899906;
    localparam int          N_STAGES    = 2 * N_DIGITS + 1;

    typedef struct packed {
        logic        kind;
        logic [31:0] rtc_count;
        logic [31:0] cali_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] uptime_us;
        logic [44:0] uptime_seconds;
        logic        restart_request;
    } out_item_t;

endpackage

// File: hw/rtl/calibrated_uptime_accumulator_top.sv
// Throughput: one beat per cycle unless out_stall backs up a full pipeline; the anchor/factor
// loop is closed combinationally through the 32x32 tick multiplier and the 64-bit anchor add.
// The seconds divide runs as an 8-stage pipeline, two stages per 16-bit digit.
// Reset (rst_n low, asynchronous) clears factor, anchor, watchdog and all valids.
module calibrated_uptime_accumulator_top
    import cua_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    typedef struct packed {
        logic [63:0]      now;
        logic             restart;
        logic [REM_W-1:0] rem;
        logic [63:0]      quot;
        logic [V_W-1:0]   v;
        logic [15:0]      qe;
    } stage_t;

    // reciprocal estimate of one quotient digit
    function automatic stage_t step_a(stage_t s, logic [DIGIT_W-1:0] digit);
        stage_t      r;
        logic [60:0] p;
        r   = s;
        r.v = {s.rem, digit};
        p   = 61'(r.v[V_W-1:6]) * 61'(RECIP_M);
        r.qe = p[RECIP_SHIFT +: 16];
        return r;
    endfunction

    // remainder and one-step correction of the digit
    function automatic stage_t step_b(stage_t s);
        stage_t         r;
        logic [V_W-1:0] rm;
        logic [15:0]    q;
        r  = s;
        rm = s.v - V_W'(36'(s.qe) * 36'(US_PER_SEC));
        q  = s.qe;
        if (rm >= V_W'(US_PER_SEC))
        begin
            q  = q + 16'd1;
            rm = rm - V_W'(US_PER_SEC);
        end
        r.rem  = rm[REM_W-1:0];
        r.quot = {s.quot[63-DIGIT_W:0], q};
        return r;
    endfunction

    logic [31:0] cal_factor_reg, cal_factor_next;
    logic [31:0] anchor_rtc_reg, anchor_rtc_next;
    logic [63:0] anchor_us_reg, anchor_us_next;
    logic [30:0] wd_left_reg, wd_left_next;

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] rdy;
    stage_t              stg_reg [N_STAGES];
    stage_t              nxt     [N_STAGES];

    logic        in_accept;
    logic        tick;
    logic [31:0] factor;
    logic [31:0] delta;
    logic [63:0] prod;
    logic [31:0] delta_us;
    logic [63:0] now;
    logic        restart;

    // stage ready chain: a stage takes a beat when empty or draining
    always_comb
    begin
        rdy[N_STAGES-1] = !vld_reg[N_STAGES-1] || !out_stall;
        for (int i = N_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign in_accept = in_valid && rdy[0];
    assign cfg_ready = 1'b1;

    // calibration, tick conversion and anchor
    always_comb
    begin
        tick     = (in_data.kind == KIND_TICK);
        factor   = (tick || cal_factor_reg == 32'd0) ? in_data.cali_value : cal_factor_reg;
        delta    = in_data.rtc_count - anchor_rtc_reg;
        prod     = 64'(delta) * 64'(factor);
        delta_us = prod[FRAC_BITS +: 32];
        now      = anchor_us_reg + 64'(delta_us);

        cal_factor_next = cal_factor_reg;
        anchor_rtc_next = anchor_rtc_reg;
        anchor_us_next  = anchor_us_reg;
        wd_left_next    = wd_left_reg;
        restart         = 1'b0;

        if (in_accept)
        begin
            cal_factor_next = factor;
            if (delta_us >= ANCHOR_MIN_US)
            begin
                anchor_rtc_next = in_data.rtc_count;
                anchor_us_next  = now;
            end
            if (tick && wd_left_reg != 31'd0)
            begin
                wd_left_next = wd_left_reg - 31'd1;
                restart      = (wd_left_reg == 31'd1);
            end
        end

        // register write reloads the countdown
        if (cfg_valid)
        begin
            wd_left_next = cfg_data;
        end
    end

    // stage 0 payload
    always_comb
    begin
        nxt[0]         = '0;
        nxt[0].now     = now;
        nxt[0].restart = restart;
    end

    // divider stages
    for (genvar k = 0; k < N_DIGITS; k++)
    begin : g_digit
        localparam int SA = 2 * k + 1;
        localparam int SB = 2 * k + 2;
        assign nxt[SA] = step_a(stg_reg[SA-1],
                                stg_reg[SA-1].now[(N_DIGITS-1-k)*DIGIT_W +: DIGIT_W]);
        assign nxt[SB] = step_b(stg_reg[SB-1]);
    end

    // control state and valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_factor_reg <= '0;
            anchor_rtc_reg <= '0;
            anchor_us_reg  <= '0;
            wd_left_reg    <= '0;
            vld_reg        <= '0;
        end
        else
        begin
            cal_factor_reg <= cal_factor_next;
            anchor_rtc_reg <= anchor_rtc_next;
            anchor_us_reg  <= anchor_us_next;
            wd_left_reg    <= wd_left_next;
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < N_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_STAGES; i++)
        begin
            if (rdy[i])
            begin
                stg_reg[i] <= nxt[i];
            end
        end
    end

    assign out_valid                = vld_reg[N_STAGES-1];
    assign out_data.uptime_us       = stg_reg[N_STAGES-1].now;
    assign out_data.uptime_seconds  = stg_reg[N_STAGES-1].quot[44:0];
    assign out_data.restart_request = stg_reg[N_STAGES-1].restart;

    // anchor only moves on an accepted beat
    a_anchor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(anchor_us_reg) && $stable(anchor_rtc_reg))
        else $error("anchor moved without an accepted beat");

    // divider remainder stays reduced at the output
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stg_reg[N_STAGES-1].rem < US_PER_SEC)
        else $error("divider remainder out of range");

    // a restart leaves the countdown expired
    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && restart && !cfg_valid |=> wd_left_reg == 31'd0)
        else $error("restart raised with countdown still running");

    // input is held off only while the first and the last stage are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0] && vld_reg[N_STAGES-1])
        else $error("input stalled with room in the pipeline");

endmodule

// File: test/uptime_checker.sv
module uptime_checker
    import cua_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    // uptime results still owed by the block, oldest first
    out_item_t   expected_uptime[$];

    // predicted block state
    logic [30:0] wd_left;
    logic [31:0] factor;
    logic [31:0] anchor_rtc;
    logic [63:0] anchor_us;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        fail_count++;
        $display("checker: %s mismatch: got %h, expected %h", what, got, want);
    endtask

    // advance the uptime state by one beat and queue the result it owes
    task automatic advance_uptime(input in_item_t beat);
        logic        is_tick;
        logic [31:0] delta_ticks;
        logic [31:0] delta_us;
        logic [63:0] product;
        logic [63:0] now_us;
        out_item_t   res;
        is_tick = (beat.kind == KIND_TICK);
        if (is_tick || factor == '0)
            factor = beat.cali_value;

        // wrapping tick interval, scaled and truncated to 32 bits
        delta_ticks = beat.rtc_count - anchor_rtc;
        product     = {32'd0, delta_ticks} * {32'd0, factor};
        delta_us    = product[FRAC_BITS +: 32];
        now_us      = anchor_us + {32'd0, delta_us};
        if (delta_us >= ANCHOR_MIN_US)
        begin
            anchor_rtc = beat.rtc_count;
            anchor_us  = now_us;
        end

        // soft watchdog steps on ticks only, fires once per load
        res.restart_request = 1'b0;
        if (is_tick && wd_left != '0)
        begin
            wd_left = wd_left - 31'd1;
            if (wd_left == '0)
                res.restart_request = 1'b1;
        end

        res.uptime_us      = now_us;
        res.uptime_seconds = 45'(now_us / 64'(US_PER_SEC));
        expected_uptime.push_back(res);
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            wd_left    = '0;
            factor     = '0;
            anchor_rtc = '0;
            anchor_us  = '0;
            expected_uptime.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wd_left  = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                if (expected_uptime.size() == 0)
                    report("unexpected result", out_data.uptime_us, '0);
                else
                begin
                    want = expected_uptime.pop_front();
                    if (out_data.uptime_us !== want.uptime_us)
                        report("uptime_us", out_data.uptime_us, want.uptime_us);
                    if (out_data.uptime_seconds !== want.uptime_seconds)
                        report("uptime_seconds", 64'(out_data.uptime_seconds),
                               64'(want.uptime_seconds));
                    if (out_data.restart_request !== want.restart_request)
                        report("restart_request", 64'(out_data.restart_request),
                               64'(want.restart_request));
                end
            end

            if (in_valid && !in_stall)
                advance_uptime(in_data);
        end
        pending = expected_uptime.size();
    end

endmodule

// File: test/calibrated_uptime_accumulator_top_test.sv
module calibrated_uptime_accumulator_top_test;
    import cua_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 210;
    localparam int TAIL_CYCLES  = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          tx_idle_max = 0;
    int          rx_idle_max = 10;
    int          stall_left  = 0;
    int          quiet_cycles = 0;
    logic        out_fire    = 1'b0;
    logic [31:0] rtc_now     = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    calibrated_uptime_accumulator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    uptime_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side: stall a random number of cycles after each taken beat
    always @(posedge clk)
    begin
        out_fire <= out_valid && !out_stall;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_fire)
                stall_left = $urandom_range(rx_idle_max, 0);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // no progress on any channel for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one input beat, after a random gap; called and returns at a falling edge
    task automatic send_beat(input logic kind, input logic [31:0] rtc, input logic [31:0] cali);
        int gap;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind, rtc_count: rtc, cali_value: cali};
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_watchdog(input logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          p;
        int          i;
        int          pick;
        logic        kind;
        logic [31:0] rtc;
        logic [31:0] cali;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: factor latching, threshold, truncation, wrap, zero factor
        send_beat(KIND_QUERY, 32'd0, 32'd0);
        send_beat(KIND_QUERY, 32'd1000, 32'h0000_1000);
        send_beat(KIND_QUERY, 32'd250000, 32'd0);
        send_beat(KIND_QUERY, 32'd250050, 32'hFFFF_FFFF);
        send_beat(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_TICK, 32'h8000_0000, 32'd0);
        send_beat(KIND_QUERY, 32'h8000_1000, 32'h0000_0800);
        send_beat(KIND_QUERY, 32'hFFFF_FFFF, 32'h1234_5678);
        send_beat(KIND_TICK, 32'd0, 32'h0000_1000);
        drain();

        // watchdog counts ticks only, fires once, then stays quiet
        write_watchdog(31'd3);
        send_beat(KIND_TICK, 32'd100, 32'h0000_6000);
        send_beat(KIND_QUERY, 32'd200, 32'h0000_5000);
        send_beat(KIND_TICK, 32'd300, 32'h0000_6000);
        send_beat(KIND_TICK, 32'd400000, 32'h0000_6000);
        send_beat(KIND_TICK, 32'd500000, 32'h0000_6000);
        drain();
        write_watchdog(31'd1);
        send_beat(KIND_TICK, 32'd600000, 32'h0000_6000);
        send_beat(KIND_TICK, 32'd600001, 32'h0000_6000);
        drain();
        write_watchdog(31'h7FFF_FFFF);
        send_beat(KIND_TICK, 32'd700000, 32'h0000_6000);
        send_beat(KIND_QUERY, 32'd800000, 32'h0000_6000);
        drain();
        write_watchdog(31'd0);
        send_beat(KIND_TICK, 32'd900000, 32'h0000_6000);
        drain();
        rtc_now = 32'd900000;

        // random phases: mostly a plausible rising RTC stream, some noise
        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: write_watchdog(31'd0);
                1: write_watchdog(31'($urandom_range(40, 1)));
                2: write_watchdog(31'h7FFF_FFFF);
                default: write_watchdog(31'($urandom));
            endcase
            tx_idle_max = (p % 3 == 0) ? 0 : 10;
            rx_idle_max = (p % 2 == 0) ? 10 : 0;

            for (i = 0; i < PHASE_BEATS; i++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 75)
                begin
                    case ($urandom_range(3, 0))
                        0: rtc_now = rtc_now + $urandom_range(100, 0);
                        1, 2: rtc_now = rtc_now + $urandom_range(400000, 0);
                        default: rtc_now = rtc_now + $urandom;
                    endcase
                    kind = ($urandom_range(3, 0) == 0) ? KIND_TICK : KIND_QUERY;
                    if ($urandom_range(31, 0) == 0)
                        cali = 32'd0;
                    else
                        cali = 32'h0000_5800 + $urandom_range(32'h1000, 0);
                    rtc = rtc_now;
                end
                else
                begin
                    kind    = ($urandom_range(1, 0) == 0) ? KIND_TICK : KIND_QUERY;
                    rtc     = $urandom;
                    cali    = $urandom;
                    rtc_now = rtc;
                end
                send_beat(kind, rtc, cali);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
